// ===== rtl/cld_pkg.sv =====
package cld_pkg;

   localparam int DEFAULT_RING_DEPTH = 128;

   localparam int KEY_W    = 8;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 8;

   localparam logic [KEY_W-1:0] KEY_NUL    = 8'h00;
   localparam logic [KEY_W-1:0] KEY_CTRL_P = 8'h10;
   localparam logic [KEY_W-1:0] KEY_CTRL_U = 8'h15;
   localparam logic [KEY_W-1:0] KEY_CTRL_H = 8'h08;
   localparam logic [KEY_W-1:0] KEY_CTRL_D = 8'h04;
   localparam logic [KEY_W-1:0] KEY_DEL    = 8'h7F;
   localparam logic [KEY_W-1:0] KEY_CR     = 8'h0D;
   localparam logic [KEY_W-1:0] KEY_LF     = 8'h0A;

   localparam logic [STATUS_W-1:0] STATUS_KEY   = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_BYTE  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_EOL   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_EOF   = 3'd4;

   localparam logic ACTION_KEY  = 1'b0;
   localparam logic ACTION_READ = 1'b1;

endpackage

// ===== rtl/console_line_discipline.sv =====
// Channel   Direction  Handshake             Payload
// request   in         start & !busy         req_action, req_key_char, req_first_of_read
// response  out        rsp_valid, one cycle  rsp_read_status, rsp_read_byte,
//                                            rsp_erased_count, rsp_line_committed,
//                                            rsp_list_processes
//
// An item is taken when start is high and busy is low. Its response strobes after dispatch
// for a read of an empty ring or any key but a line kill, after dispatch and read-data for
// other reads, and for a line kill after dispatch, a look and a test per erased character and
// a last look, the ring read via its single port. A new item may start with the strobe.
// Synchronous reset empties the ring by clearing the three pointers; ring contents are not
// cleared. The receiver cannot stall: each response is valid for exactly one cycle.
module console_line_discipline #(
   parameter int RING_DEPTH = cld_pkg::DEFAULT_RING_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_action,
   input  logic [cld_pkg::KEY_W-1:0]     req_key_char,
   input  logic                          req_first_of_read,
   output logic                          rsp_valid,
   output logic [cld_pkg::STATUS_W-1:0]  rsp_read_status,
   output logic [cld_pkg::KEY_W-1:0]     rsp_read_byte,
   output logic [cld_pkg::COUNT_W-1:0]   rsp_erased_count,
   output logic                          rsp_line_committed,
   output logic                          rsp_list_processes
);

   localparam int AW = $clog2(RING_DEPTH);
   localparam int PW = $clog2(2 * RING_DEPTH);
   localparam logic [PW:0]   PTR_MOD  = (PW+1)'(2 * RING_DEPTH);
   localparam logic [PW-1:0] PTR_LAST = PW'(2 * RING_DEPTH - 1);
   localparam logic [PW-1:0] DEPTH_P  = PW'(RING_DEPTH);
   localparam logic [PW-1:0] DEPTH_M1 = PW'(RING_DEPTH - 1);
   localparam logic [cld_pkg::COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_READ_DATA,
      ST_KILL_LOOK,
      ST_KILL_TEST
   } state_type;

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
      return (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
      return (p == '0) ? PTR_LAST : p - 1'b1;
   endfunction

   function automatic logic [PW-1:0] ptr_diff(input logic [PW-1:0] a, input logic [PW-1:0] b);
      logic [PW:0] t;
      t = (a >= b) ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + PTR_MOD - {1'b0, b});
      return t[PW-1:0];
   endfunction

   function automatic logic [AW-1:0] slot(input logic [PW-1:0] p);
      logic [PW-1:0] t;
      t = (p >= DEPTH_P) ? p - DEPTH_P : p;
      return t[AW-1:0];
   endfunction

   state_type                       state_ff, state_in;
   logic                            action_ff, action_in;
   logic [cld_pkg::KEY_W-1:0]       key_ff, key_in;
   logic                            first_ff, first_in;
   logic [PW-1:0]                   fill_ff, fill_in;
   logic [PW-1:0]                   rd_ptr_ff, rd_ptr_in;
   logic [PW-1:0]                   commit_ptr_ff, commit_ptr_in;
   logic [PW-1:0]                   edit_ptr_ff, edit_ptr_in;
   logic [cld_pkg::COUNT_W-1:0]     erased_ff, erased_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [cld_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [cld_pkg::KEY_W-1:0]       rsp_byte_ff, rsp_byte_in;
   logic [cld_pkg::COUNT_W-1:0]     rsp_erased_ff, rsp_erased_in;
   logic                            rsp_committed_ff, rsp_committed_in;
   logic                            rsp_plist_ff, rsp_plist_in;

   logic                            ram_wr_en;
   logic [AW-1:0]                   ram_wr_addr;
   logic [cld_pkg::KEY_W-1:0]       ram_wr_data;
   logic                            ram_rd_en;
   logic [AW-1:0]                   ram_rd_addr;
   logic [cld_pkg::KEY_W-1:0]       ram_rd_data;
   logic [cld_pkg::KEY_W-1:0]       stored_char;

   cld_ram #(
      .WIDTH (cld_pkg::KEY_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign stored_char = (key_ff == cld_pkg::KEY_CR) ? cld_pkg::KEY_LF : key_ff;

   always_comb begin
      state_in         = state_ff;
      action_in        = action_ff;
      key_in           = key_ff;
      first_in         = first_ff;
      fill_in          = fill_ff;
      rd_ptr_in        = rd_ptr_ff;
      commit_ptr_in    = commit_ptr_ff;
      edit_ptr_in      = edit_ptr_ff;
      erased_in        = erased_ff;
      rsp_valid_in     = 1'b0;
      rsp_status_in    = rsp_status_ff;
      rsp_byte_in      = rsp_byte_ff;
      rsp_erased_in    = rsp_erased_ff;
      rsp_committed_in = rsp_committed_ff;
      rsp_plist_in     = rsp_plist_ff;
      ram_wr_en        = 1'b0;
      ram_wr_addr      = slot(edit_ptr_ff);
      ram_wr_data      = stored_char;
      ram_rd_en        = 1'b0;
      ram_rd_addr      = slot(rd_ptr_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               action_in = req_action;
               key_in    = req_key_char;
               first_in  = req_first_of_read;
               fill_in   = ptr_diff(edit_ptr_ff, rd_ptr_ff);
               erased_in = '0;
               state_in  = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            rsp_status_in    = cld_pkg::STATUS_KEY;
            rsp_byte_in      = '0;
            rsp_erased_in    = '0;
            rsp_committed_in = 1'b0;
            rsp_plist_in     = 1'b0;
            state_in         = ST_IDLE;
            if (action_ff == cld_pkg::ACTION_READ) begin
               if (rd_ptr_ff == commit_ptr_ff) begin
                  rsp_status_in = cld_pkg::STATUS_EMPTY;
                  rsp_valid_in  = 1'b1;
               end else begin
                  ram_rd_en = 1'b1;
                  state_in  = ST_READ_DATA;
               end
            end else if (key_ff == cld_pkg::KEY_CTRL_P) begin
               rsp_plist_in = 1'b1;
               rsp_valid_in = 1'b1;
            end else if (key_ff == cld_pkg::KEY_CTRL_U) begin
               state_in = ST_KILL_LOOK;
            end else if (key_ff == cld_pkg::KEY_CTRL_H || key_ff == cld_pkg::KEY_DEL) begin
               if (edit_ptr_ff != commit_ptr_ff) begin
                  edit_ptr_in   = ptr_dec(edit_ptr_ff);
                  rsp_erased_in = cld_pkg::COUNT_W'(1);
               end
               rsp_valid_in = 1'b1;
            end else begin
               if (key_ff != cld_pkg::KEY_NUL && fill_ff < DEPTH_P) begin
                  ram_wr_en   = 1'b1;
                  edit_ptr_in = ptr_inc(edit_ptr_ff);
                  if (stored_char == cld_pkg::KEY_LF || stored_char == cld_pkg::KEY_CTRL_D ||
                      fill_ff == DEPTH_M1) begin
                     commit_ptr_in    = ptr_inc(edit_ptr_ff);
                     rsp_committed_in = 1'b1;
                  end
               end
               rsp_valid_in = 1'b1;
            end
         end
         ST_READ_DATA: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            if (ram_rd_data == cld_pkg::KEY_CTRL_D) begin
               rsp_status_in = cld_pkg::STATUS_EOF;
               rsp_byte_in   = '0;
               if (first_ff) begin
                  rd_ptr_in = ptr_inc(rd_ptr_ff);
               end
            end else begin
               rd_ptr_in     = ptr_inc(rd_ptr_ff);
               rsp_byte_in   = ram_rd_data;
               rsp_status_in = (ram_rd_data == cld_pkg::KEY_LF) ? cld_pkg::STATUS_EOL
                                                                 : cld_pkg::STATUS_BYTE;
            end
         end
         ST_KILL_LOOK: begin
            ram_rd_addr = slot(ptr_dec(edit_ptr_ff));
            if (edit_ptr_ff == commit_ptr_ff) begin
               rsp_erased_in = erased_ff;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               ram_rd_en = 1'b1;
               state_in  = ST_KILL_TEST;
            end
         end
         ST_KILL_TEST: begin
            if (ram_rd_data == cld_pkg::KEY_LF) begin
               rsp_erased_in = erased_ff;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               edit_ptr_in = ptr_dec(edit_ptr_ff);
               if (erased_ff != COUNT_MAX) begin
                  erased_in = erased_ff + 1'b1;
               end
               state_in = ST_KILL_LOOK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_ptr_ff     <= '0;
         commit_ptr_ff <= '0;
         edit_ptr_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_ptr_ff     <= rd_ptr_in;
         commit_ptr_ff <= commit_ptr_in;
         edit_ptr_ff   <= edit_ptr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      action_ff        <= action_in;
      key_ff           <= key_in;
      first_ff         <= first_in;
      fill_ff          <= fill_in;
      erased_ff        <= erased_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_byte_ff      <= rsp_byte_in;
      rsp_erased_ff    <= rsp_erased_in;
      rsp_committed_ff <= rsp_committed_in;
      rsp_plist_ff     <= rsp_plist_in;
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_status    = rsp_status_ff;
   assign rsp_read_byte      = rsp_byte_ff;
   assign rsp_erased_count   = rsp_erased_ff;
   assign rsp_line_committed = rsp_committed_ff;
   assign rsp_list_processes = rsp_plist_ff;

   logic [PW-1:0] edit_fill;
   logic [PW-1:0] commit_fill;

   assign edit_fill   = ptr_diff(edit_ptr_ff, rd_ptr_ff);
   assign commit_fill = ptr_diff(commit_ptr_ff, rd_ptr_ff);

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("response strobe lasted more than one cycle");

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transfer did not make the block busy");

   a_ring_bound: assert property (@(posedge clock) disable iff (reset)
      edit_fill <= DEPTH_P)
      else $error("ring holds more characters than its depth");

   a_commit_order: assert property (@(posedge clock) disable iff (reset)
      commit_fill <= edit_fill)
      else $error("commit pointer lies beyond the edit pointer");

   a_key_no_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == cld_pkg::STATUS_KEY) |-> (rsp_byte_ff == '0))
      else $error("key response carried a read byte");

endmodule

// ===== rtl/cld_ram.sv =====
module cld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
